### rtl/admr_pkg.sv
// Shared constants, command codes and controller/datapath interface types
// for the arcade drive mixer. No dependencies.
package admr_pkg;

    // Serial divider sizing: the widest dividend is the doubled gain product.
    localparam int DIV_W = 35;
    localparam int DSR_W = 17;
    localparam int CNT_W = $clog2(DIV_W + 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_SCL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_SCL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_GAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_GAIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_MIN  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_MAX  = 3'd6;

    // Division selects for the shared divider.
    typedef logic [2:0] t_div_op;

    localparam t_div_op DOP_RMIN  = 3'd0;
    localparam t_div_op DOP_RMAX  = 3'd1;
    localparam t_div_op DOP_RATIO = 3'd2;
    localparam t_div_op DOP_LEFT  = 3'd3;
    localparam t_div_op DOP_RIGHT = 3'd4;

    typedef struct packed {
        logic    load;
        logic    div_start;
        t_div_op div_op;
        logic    div_capture;
        logic    mul_step;
        logic    update;
        logic    mul_scale;
        logic    scale;
        logic    mul_gain;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic ramp;
    } t_dp_status;

endpackage

### rtl/admr_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on admr_pkg for the operand widths.
module admr_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [admr_pkg::DIV_W-1:0]  i_dividend,
    input  logic [admr_pkg::DSR_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [admr_pkg::DIV_W-1:0]  o_quotient
);

    logic                        r_busy;
    logic                        r_done;
    logic [admr_pkg::CNT_W-1:0]  r_cnt;
    logic [admr_pkg::DSR_W-1:0]  r_rem;
    logic [admr_pkg::DIV_W-1:0]  r_quo;
    logic [admr_pkg::DSR_W-1:0]  r_dsr;

    logic [admr_pkg::DSR_W:0]    shifted;
    logic [admr_pkg::DSR_W+1:0]  trial;
    logic                        qbit;
    logic [admr_pkg::DSR_W-1:0]  n_rem;

    assign shifted = {r_rem, r_quo[admr_pkg::DIV_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, r_dsr};
    assign qbit    = !trial[admr_pkg::DSR_W+1];
    // The partial remainder stays below the divisor, so it fits DSR_W bits.
    assign n_rem   = qbit ? trial[admr_pkg::DSR_W-1:0] : shifted[admr_pkg::DSR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == admr_pkg::CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= admr_pkg::CNT_W'(admr_pkg::DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - admr_pkg::CNT_W'(1);
                if (r_cnt == admr_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[admr_pkg::DIV_W-2:0], qbit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### rtl/admr_ctrl.sv
// Sequencing state machine for the arcade drive mixer: input and output
// handshakes and the command stream to the datapath. Depends on admr_pkg.
module admr_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output admr_pkg::t_dp_cmd     o_cmd,
    input  admr_pkg::t_dp_status  i_status
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DIV_MIN   = 4'd1;
    localparam logic [3:0] S_DIV_MAX   = 4'd2;
    localparam logic [3:0] S_MUL_STEP  = 4'd3;
    localparam logic [3:0] S_UPDATE    = 4'd4;
    localparam logic [3:0] S_MUL_SCALE = 4'd5;
    localparam logic [3:0] S_SCALE     = 4'd6;
    localparam logic [3:0] S_DIV_RATIO = 4'd7;
    localparam logic [3:0] S_MUL_GAIN  = 4'd8;
    localparam logic [3:0] S_DIV_LEFT  = 4'd9;
    localparam logic [3:0] S_DIV_RIGHT = 4'd10;
    localparam logic [3:0] S_DONE      = 4'd11;

    logic [3:0]        r_state;
    logic [3:0]        n_state;
    logic              r_started;
    logic              n_started;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              div_state;
    admr_pkg::t_div_op div_op;
    logic [3:0]        div_next;
    admr_pkg::t_dp_cmd cmd;

    always_comb begin
        n_state   = r_state;
        n_started = r_started;
        cmd       = '0;
        div_state = 1'b0;
        div_op    = admr_pkg::DOP_RMIN;
        div_next  = S_IDLE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_DIV_MIN;
                end
            end
            S_DIV_MIN: begin
                // Without ramping the rate divisions are not needed.
                if (!i_status.ramp) begin
                    n_state = S_UPDATE;
                end else begin
                    div_state = 1'b1;
                    div_op    = admr_pkg::DOP_RMIN;
                    div_next  = S_DIV_MAX;
                end
            end
            S_DIV_MAX: begin
                div_state = 1'b1;
                div_op    = admr_pkg::DOP_RMAX;
                div_next  = S_MUL_STEP;
            end
            S_MUL_STEP: begin
                cmd.mul_step = 1'b1;
                n_state      = S_UPDATE;
            end
            S_UPDATE: begin
                cmd.update = 1'b1;
                n_state    = S_MUL_SCALE;
            end
            S_MUL_SCALE: begin
                cmd.mul_scale = 1'b1;
                n_state       = S_SCALE;
            end
            S_SCALE: begin
                cmd.scale = 1'b1;
                n_state   = S_DIV_RATIO;
            end
            S_DIV_RATIO: begin
                div_state = 1'b1;
                div_op    = admr_pkg::DOP_RATIO;
                div_next  = S_MUL_GAIN;
            end
            S_MUL_GAIN: begin
                cmd.mul_gain = 1'b1;
                n_state      = S_DIV_LEFT;
            end
            S_DIV_LEFT: begin
                div_state = 1'b1;
                div_op    = admr_pkg::DOP_LEFT;
                div_next  = S_DIV_RIGHT;
            end
            S_DIV_RIGHT: begin
                div_state = 1'b1;
                div_op    = admr_pkg::DOP_RIGHT;
                div_next  = S_DONE;
            end
            S_DONE: begin
                // The result register is free once its last result transfers.
                if (!r_out_valid || !i_out_stall) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (div_state) begin
            cmd.div_op    = div_op;
            cmd.div_start = !r_started;
            n_started     = !i_status.div_done;
            if (i_status.div_done) begin
                cmd.div_capture = 1'b1;
                n_state         = div_next;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_started   <= n_started;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### rtl/admr_datapath.sv
// Datapath of the arcade drive mixer: configuration registers, throttle
// ramp state, multipliers, the shared serial divider and the result register.
// Depends on admr_pkg and admr_div.
module admr_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [admr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [admr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic signed [15:0]                i_turn_in,
    input  logic signed [15:0]                i_throttle_in,
    input  logic                              i_ramp_enable,
    input  logic [14:0]                       i_battery_mv,
    input  admr_pkg::t_dp_cmd                 i_cmd,
    output admr_pkg::t_dp_status              o_status,
    output logic signed [15:0]                o_left_drive,
    output logic signed [15:0]                o_right_drive,
    output logic signed [15:0]                o_ramped_throttle
);

    function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
        if (v > 19'sd32767) begin
            sat16 = 16'sh7FFF;
        end else if (v < -19'sd32767) begin
            sat16 = 16'sh8001;
        end else begin
            sat16 = v[15:0];
        end
    endfunction

    // Division by 16384 rounding toward zero.
    function automatic logic signed [17:0] trunc_q14(input logic signed [31:0] v);
        logic signed [31:0] biased;
        biased    = v[31] ? v + 32'sd16383 : v;
        trunc_q14 = biased[31:14];
    endfunction

    function automatic logic signed [15:0] sat_quot(input logic [admr_pkg::DIV_W-1:0] q,
                                                    input logic neg);
        logic [15:0] mag;
        mag      = (q > admr_pkg::DIV_W'(32767)) ? 16'd32767 : {1'b0, q[14:0]};
        sat_quot = neg ? -$signed(mag) : $signed(mag);
    endfunction

    // Configuration registers.
    logic                r_reverse;
    logic [14:0]         r_turn_scl;
    logic [14:0]         r_thr_scl;
    logic signed [15:0]  r_left_gain;
    logic signed [15:0]  r_right_gain;
    logic [14:0]         r_ramp_min;
    logic [14:0]         r_ramp_max;

    // Item and working registers.
    logic signed [15:0]  r_x;
    logic signed [15:0]  r_t;
    logic                r_ramp;
    logic [14:0]         r_bat;
    logic signed [15:0]  r_prev;
    logic [29:0]         r_rmin;
    logic [29:0]         r_rmax;
    logic [45:0]         r_prod;
    logic signed [31:0]  r_pm;
    logic signed [31:0]  r_qm;
    logic signed [17:0]  r_p;
    logic signed [17:0]  r_q;
    logic signed [34:0]  r_lm;
    logic signed [34:0]  r_rm;
    logic [16:0]         r_d;
    logic signed [15:0]  r_left;
    logic signed [15:0]  r_right;
    logic signed [15:0]  r_out_left;
    logic signed [15:0]  r_out_right;
    logic signed [15:0]  r_out_thr;

    // Load-time conditioning.
    logic signed [15:0]  x_sat;
    logic signed [18:0]  t_wide;
    logic signed [18:0]  t_rev;
    logic [14:0]         bat_fix;

    // Magnitudes for the mixing ratio.
    logic [15:0]         ax_full;
    logic [15:0]         at_full;
    logic [14:0]         ax;
    logic [14:0]         at;
    logic [14:0]         lo;
    logic [14:0]         hi;
    logic                hi_zero;

    // Ramp step.
    logic signed [16:0]  diff_tp;
    logic [15:0]         delta;
    logic [30:0]         step_raw;
    logic [30:0]         step_min;
    logic [16:0]         step_clip;
    logic signed [18:0]  prev_w;
    logic signed [18:0]  step_w;
    logic signed [18:0]  prev_next_w;
    logic                snap;
    logic signed [15:0]  prev_next;

    // Mixing.
    logic signed [18:0]  diff_pq;
    logic signed [18:0]  sum_pq;
    logic signed [35:0]  lm2;
    logic signed [35:0]  rm2;
    logic [35:0]         l_mag;
    logic [35:0]         r_mag;

    // Divider.
    logic [admr_pkg::DIV_W-1:0] div_dividend;
    logic [admr_pkg::DSR_W-1:0] div_divisor;
    logic                       div_done;
    logic [admr_pkg::DIV_W-1:0] div_quot;

    assign x_sat   = (i_turn_in == 16'sh8000) ? 16'sh8001 : i_turn_in;
    assign t_wide  = {{3{i_throttle_in[15]}}, i_throttle_in};
    assign t_rev   = r_reverse ? -t_wide : t_wide;
    assign bat_fix = (i_battery_mv == 15'd0) ? 15'd1 : i_battery_mv;

    assign ax_full = r_x[15] ? 16'(-r_x) : 16'(r_x);
    assign at_full = r_t[15] ? 16'(-r_t) : 16'(r_t);
    assign ax      = ax_full[14:0];
    assign at      = at_full[14:0];
    assign lo      = (ax < at) ? ax : at;
    assign hi      = (ax < at) ? at : ax;
    assign hi_zero = (hi == 15'd0);

    assign diff_tp   = {r_t[15], r_t} - {r_prev[15], r_prev};
    assign delta     = diff_tp[16] ? 16'(-diff_tp) : diff_tp[15:0];
    assign step_raw  = r_prod[45:15];
    assign step_min  = (step_raw < {1'b0, r_rmin}) ? {1'b0, r_rmin} : step_raw;
    assign step_clip = (step_min > 31'd65536) ? 17'd65536 : step_min[16:0];
    assign prev_w    = {{3{r_prev[15]}}, r_prev};
    assign step_w    = $signed({2'b00, step_clip});
    assign prev_next_w = (r_prev < r_t) ? prev_w + step_w : prev_w - step_w;
    // A small gap snaps straight to the target, as does pass-through mode.
    assign snap      = !r_ramp || ({14'd0, delta} <= r_rmin);
    assign prev_next = snap ? r_t : sat16(prev_next_w);

    assign diff_pq = {r_p[17], r_p} - {r_q[17], r_q};
    assign sum_pq  = {r_p[17], r_p} + {r_q[17], r_q};
    assign lm2     = {r_lm, 1'b0};
    assign rm2     = {r_rm, 1'b0};
    assign l_mag   = lm2[35] ? 36'(-lm2) : 36'(lm2);
    assign r_mag   = rm2[35] ? 36'(-rm2) : 36'(rm2);

    always_comb begin
        case (i_cmd.div_op)
            admr_pkg::DOP_RMIN: begin
                div_dividend = {5'd0, r_ramp_min, 15'd0};
                div_divisor  = {2'd0, r_bat};
            end
            admr_pkg::DOP_RMAX: begin
                div_dividend = {5'd0, r_ramp_max, 15'd0};
                div_divisor  = {2'd0, r_bat};
            end
            admr_pkg::DOP_RATIO: begin
                div_dividend = {5'd0, lo, 15'd0};
                div_divisor  = {2'd0, hi};
            end
            admr_pkg::DOP_LEFT: begin
                div_dividend = l_mag[admr_pkg::DIV_W-1:0];
                div_divisor  = r_d;
            end
            admr_pkg::DOP_RIGHT: begin
                div_dividend = r_mag[admr_pkg::DIV_W-1:0];
                div_divisor  = r_d;
            end
            default: begin
                div_dividend = '0;
                div_divisor  = '0;
            end
        endcase
    end

    admr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reverse    <= 1'b0;
            r_turn_scl   <= 15'd16384;
            r_thr_scl    <= 15'd16384;
            r_left_gain  <= 16'sd16384;
            r_right_gain <= 16'sd16384;
            r_ramp_min   <= 15'd240;
            r_ramp_max   <= 15'd1200;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                admr_pkg::CFG_REVERSE:    r_reverse    <= i_cfg_data[0];
                admr_pkg::CFG_TURN_SCL:   r_turn_scl   <= i_cfg_data[14:0];
                admr_pkg::CFG_THR_SCL:    r_thr_scl    <= i_cfg_data[14:0];
                admr_pkg::CFG_LEFT_GAIN:  r_left_gain  <= $signed(i_cfg_data);
                admr_pkg::CFG_RIGHT_GAIN: r_right_gain <= $signed(i_cfg_data);
                admr_pkg::CFG_RAMP_MIN:   r_ramp_min   <= i_cfg_data[14:0];
                admr_pkg::CFG_RAMP_MAX:   r_ramp_max   <= i_cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (i_cmd.update) begin
            r_prev <= prev_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= x_sat;
            r_t    <= sat16(t_rev);
            r_ramp <= i_ramp_enable;
            r_bat  <= bat_fix;
        end
        if (i_cmd.mul_step) begin
            r_prod <= delta * r_rmax;
        end
        if (i_cmd.mul_scale) begin
            r_pm <= r_prev * $signed({1'b0, r_thr_scl});
            r_qm <= r_x * $signed({1'b0, r_turn_scl});
        end
        if (i_cmd.scale) begin
            r_p <= r_ramp ? trunc_q14(r_pm) : {{2{r_t[15]}}, r_t};
            r_q <= r_ramp ? trunc_q14(r_qm) : {{2{r_x[15]}}, r_x};
        end
        if (i_cmd.mul_gain) begin
            r_lm <= diff_pq * r_left_gain;
            r_rm <= sum_pq * r_right_gain;
        end
        if (i_cmd.div_capture) begin
            case (i_cmd.div_op)
                admr_pkg::DOP_RMIN:  r_rmin <= div_quot[29:0];
                admr_pkg::DOP_RMAX:  r_rmax <= div_quot[29:0];
                admr_pkg::DOP_RATIO: begin
                    r_d <= hi_zero ? 17'd32768 : 17'd32768 + {1'b0, div_quot[15:0]};
                end
                admr_pkg::DOP_LEFT:  r_left  <= sat_quot(div_quot, r_lm[34]);
                admr_pkg::DOP_RIGHT: r_right <= sat_quot(div_quot, r_rm[34]);
                default: begin
                end
            endcase
        end
        if (i_cmd.out_load) begin
            r_out_left  <= r_left;
            r_out_right <= r_right;
            r_out_thr   <= r_prev;
        end
    end

    assign o_status.div_done = div_done;
    assign o_status.ramp     = r_ramp;
    assign o_left_drive      = r_out_left;
    assign o_right_drive     = r_out_right;
    assign o_ramped_throttle = r_out_thr;

endmodule

### rtl/arcade_drive_mixer_with_ramp.sv
// Top level of the arcade drive mixer with throttle ramp; instantiates
// admr_ctrl and admr_datapath and uses admr_pkg. Each transfer on the input
// channel yields exactly one transfer on the output channel. All divisions
// go through one shared divider that produces one quotient bit per cycle,
// and that divider sets the rate: an item takes five divisions with ramping
// enabled and three with ramping disabled, and the next item is taken only
// once the last one is through. A finished result waits in the output
// register, so the next item is taken while it is still stalled.
// Configuration writes are always ready and must only be issued while the
// block is idle.
module arcade_drive_mixer_with_ramp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [15:0]                i_turn_in,
    input  logic signed [15:0]                i_throttle_in,
    input  logic                              i_ramp_enable,
    input  logic [14:0]                       i_battery_mv,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [15:0]                o_left_drive,
    output logic signed [15:0]                o_right_drive,
    output logic signed [15:0]                o_ramped_throttle,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [admr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [admr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    admr_pkg::t_dp_cmd    cmd;
    admr_pkg::t_dp_status status;

    assign o_cfg_ready = 1'b1;

    admr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    admr_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_turn_in         (i_turn_in),
        .i_throttle_in     (i_throttle_in),
        .i_ramp_enable     (i_ramp_enable),
        .i_battery_mv      (i_battery_mv),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_left_drive      (o_left_drive),
        .o_right_drive     (o_right_drive),
        .o_ramped_throttle (o_ramped_throttle)
    );

endmodule

### rtl/admr_checker.sv
// Port-level assertions for the arcade drive mixer, attached to the top
// level by the bind statement at the end. No package dependencies.
module admr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [15:0] o_left_drive,
    input logic signed [15:0] o_right_drive,
    input logic signed [15:0] o_ramped_throttle
);

    // Accepting an item moves the controller out of idle, so a transfer is never directly followed by another.
    a_one_item_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted in back-to-back cycles");

    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_out_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            ($stable(o_left_drive) && $stable(o_right_drive) && $stable(o_ramped_throttle)))
        else $error("output payload changed while stalled");

    // Saturation keeps every result off the most negative code.
    a_outputs_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_left_drive != 16'sh8000 && o_right_drive != 16'sh8000 &&
                         o_ramped_throttle != 16'sh8000))
        else $error("result outside the saturated range");

endmodule

bind arcade_drive_mixer_with_ramp admr_checker u_checker (.*);
